FILE: design/modexp_pkg.sv
// package for the modular exponentiation block
// shared widths, sequencer state and multiply target codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

  // width of the word fields on the channels
  localparam int FIELD_W = 63;
  // operand width used inside the block (8..63), upper field bits are ignored
  localparam int OP_W    = 63;
  localparam int CNT_W   = $clog2(OP_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_PCHK,
    S_PSHIFT,
    S_MUL,
    S_DONE
  } state_t;

  // where a finished modular product is written
  typedef enum logic [1:0] {
    TGT_ACC,
    TGT_X,
    TGT_OUT
  } target_t;

endpackage : modexp_pkg

`default_nettype wire

FILE: design/modexp_if.sv
// valid/ready channel interfaces for request and response words
// depends on modexp_pkg for the field width
`timescale 1ns / 1ps
`default_nettype none

interface modexp_req_if
  import modexp_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [FIELD_W-1:0] base;
  logic [FIELD_W-1:0] exponent;
  logic [FIELD_W-1:0] modulus;

  modport source (output valid, mode, base, exponent, modulus, input ready);
  modport sink   (input valid, mode, base, exponent, modulus, output ready);
endinterface : modexp_req_if

interface modexp_rsp_if
  import modexp_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] result;
  logic               error;

  modport source (output valid, result, error, input ready);
  modport sink   (input valid, result, error, output ready);
endinterface : modexp_rsp_if

`default_nettype wire

FILE: design/modular_exponentiation.sv
// modular power / modular product on one shared add-double unit
// sequence: a zero modulus goes straight to done; a product reduces both factors, then multiplies;
//   a power reduces the base, then per exponent bit multiplies on a set bit and squares the base
//   while higher exponent bits remain
// throughput: one word at a time; a new word is taken while a finished result still waits
// reset: synchronous active-high rst returns the sequencer to idle and drops response valid
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation
  import modexp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  modexp_req_if.sink   req,
  modexp_rsp_if.source rsp
);

  // sequencer
  state_t state, state_next;

  // operand and working registers
  logic                mode_r;
  logic [OP_W-1:0]     m;        // modulus
  logic [OP_W-1:0]     e;        // exponent bits still to scan
  logic [OP_W-1:0]     acc;      // power accumulator, also final result
  logic [OP_W-1:0]     xr;       // reduced base, squared in place
  logic [OP_W-1:0]     mx;       // doubled operand / partial remainder
  logic [OP_W-1:0]     my;       // scanned multiplier / dividend shifter
  logic [OP_W-1:0]     macc;     // product accumulator
  logic [CNT_W-1:0]    cnt;      // reduction step count
  target_t             tgt;
  logic                err;

  // response holding register
  logic                rsp_valid;
  logic [FIELD_W-1:0]  rsp_result;
  logic                rsp_error;

  // shared add-double unit: one modular doubling (with shift-in bit) and one modular add
  logic                dbl_in;
  logic [OP_W:0]       dbl_sum, dbl_dif, add_sum, add_dif;
  logic [OP_W-1:0]     dbl_res, add_res;

  logic                acc_req;  // request accepted
  logic                out_free; // response slot can take a word
  logic                red_last;
  logic                mul_end;
  logic                e_more;   // exponent has bits left after this shift

  // restoring reduction shifts the dividend top bit into the partial remainder
  assign dbl_in  = (state == S_RED_A || state == S_RED_B) ? my[OP_W-1] : 1'b0;
  assign dbl_sum = {mx, dbl_in};
  assign dbl_dif = dbl_sum - {1'b0, m};
  assign dbl_res = (dbl_sum >= {1'b0, m}) ? dbl_dif[OP_W-1:0] : dbl_sum[OP_W-1:0];

  assign add_sum = {1'b0, macc} + {1'b0, mx};
  assign add_dif = add_sum - {1'b0, m};
  assign add_res = (add_sum >= {1'b0, m}) ? add_dif[OP_W-1:0] : add_sum[OP_W-1:0];

  assign acc_req  = req.valid && req.ready;
  assign out_free = !rsp_valid || rsp.ready;
  assign red_last = (cnt == CNT_W'(OP_W - 1));
  assign mul_end  = (my == '0);
  assign e_more   = (e[OP_W-1:1] != '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc_req) begin
          if (req.modulus[OP_W-1:0] == '0) state_next = S_DONE;
          else                              state_next = S_RED_A;
        end
      end
      S_RED_A: begin
        if (red_last) state_next = mode_r ? S_RED_B : S_PCHK;
      end
      S_RED_B: begin
        if (red_last) state_next = S_MUL;
      end
      S_PCHK: begin
        if (e == '0)   state_next = S_DONE;
        else if (e[0]) state_next = S_MUL;
        else           state_next = S_PSHIFT;
      end
      S_PSHIFT: begin
        state_next = e_more ? S_MUL : S_PCHK;
      end
      S_MUL: begin
        if (mul_end) begin
          unique case (tgt)
            TGT_ACC: state_next = S_PSHIFT;
            TGT_X:   state_next = S_PCHK;
            TGT_OUT: state_next = S_DONE;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // channel outputs
  always_comb begin
    req.ready  = (state == S_IDLE);
    rsp.valid  = rsp_valid;
    rsp.result = rsp_result;
    rsp.error  = rsp_error;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // response slot
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp_result <= FIELD_W'(acc);
      rsp_error  <= err;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (acc_req) begin
          mode_r <= req.mode;
          m      <= req.modulus[OP_W-1:0];
          e      <= req.exponent[OP_W-1:0];
          mx     <= '0;
          my     <= req.base[OP_W-1:0];
          cnt    <= '0;
          err    <= (req.modulus[OP_W-1:0] == '0);
          acc    <= '0;
        end
      end
      S_RED_A: begin
        if (red_last) begin
          xr  <= dbl_res;
          // 1 mod m: zero when the modulus is one
          acc <= (m == OP_W'(1)) ? '0 : OP_W'(1);
          // product mode reduces the second factor next
          mx  <= '0;
          my  <= e;
          cnt <= '0;
        end else begin
          mx  <= dbl_res;
          my  <= {my[OP_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
        end
      end
      S_RED_B: begin
        if (red_last) begin
          mx   <= xr;
          my   <= dbl_res;
          macc <= '0;
          tgt  <= TGT_OUT;
        end else begin
          mx  <= dbl_res;
          my  <= {my[OP_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
        end
      end
      S_PCHK: begin
        if (e[0]) begin
          mx   <= acc;
          my   <= xr;
          macc <= '0;
          tgt  <= TGT_ACC;
        end
      end
      S_PSHIFT: begin
        e <= {1'b0, e[OP_W-1:1]};
        if (e_more) begin
          mx   <= xr;
          my   <= xr;
          macc <= '0;
          tgt  <= TGT_X;
        end
      end
      S_MUL: begin
        if (mul_end) begin
          unique case (tgt)
            TGT_X:   xr  <= macc;
            TGT_ACC: acc <= macc;
            TGT_OUT: acc <= macc;
            default: acc <= macc;
          endcase
        end else begin
          // one double-and-add step: add on a set multiplier bit, then double
          if (my[0]) macc <= add_res;
          mx <= dbl_res;
          my <= {1'b0, my[OP_W-1:1]};
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule : modular_exponentiation

`default_nettype wire

FILE: bench/modular_exponentiation_tb.sv
// self-checking testbench for modular_exponentiation, power and product modes
// depends on modexp_pkg, modexp_req_if / modexp_rsp_if and the block itself
`timescale 1ns / 1ps

module modular_exponentiation_tb;
  import modexp_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 5_000_000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam bit [63:0]   OP_MASK       = (64'd1 << OP_W) - 64'd1;
  localparam bit [FIELD_W-1:0] ALL_ONES = '1;

  // mode bit values on the request word
  localparam bit MODE_POWER   = 1'b0;
  localparam bit MODE_PRODUCT = 1'b1;

  typedef struct packed {
    logic [FIELD_W-1:0] result;
    logic               error;
  } answer_t;

  logic clk = 1'b0;
  logic rst;

  modexp_req_if req ();
  modexp_rsp_if rsp ();

  modular_exponentiation dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  answer_t     answer_q[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          steady_flow = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // arithmetic predictor
  // ---------------------------------------------------------------------------

  // (x + y) mod m with x, y < m < 2^63, so the sum never wraps 64 bits
  function automatic bit [63:0] add_reduce(bit [63:0] x, bit [63:0] y, bit [63:0] m);
    bit [63:0] s;
    s = x + y;
    return (s >= m) ? s - m : s;
  endfunction

  // x * y mod m by doubling x and adding it in for each set bit of y
  function automatic bit [63:0] mul_reduce(bit [63:0] x, bit [63:0] y, bit [63:0] m);
    bit [63:0] acc;
    acc = 64'd0;
    x   = x % m;
    y   = y % m;
    while (y != 64'd0) begin
      if (y[0])
        acc = add_reduce(acc, x, m);
      x = add_reduce(x, x, m);
      y = y >> 1;
    end
    return acc;
  endfunction

  // x^e mod m, exponent scanned lsb first; 1 % m makes modulus one give 0
  function automatic bit [63:0] pow_reduce(bit [63:0] x, bit [63:0] e, bit [63:0] m);
    bit [63:0] acc;
    acc = 64'd1 % m;
    x   = x % m;
    while (e != 64'd0) begin
      if (e[0])
        acc = mul_reduce(acc, x, m);
      e = e >> 1;
      if (e != 64'd0)
        x = mul_reduce(x, x, m);
    end
    return acc;
  endfunction

  function automatic answer_t predict_answer(bit mode, bit [FIELD_W-1:0] a,
                                             bit [FIELD_W-1:0] b, bit [FIELD_W-1:0] m);
    bit [63:0] av;
    bit [63:0] bv;
    bit [63:0] mv;
    bit [63:0] r;
    answer_t   ans;
    av = 64'(a) & OP_MASK;
    bv = 64'(b) & OP_MASK;
    mv = 64'(m) & OP_MASK;
    if (mv == 64'd0) begin
      ans.result = '0;
      ans.error  = 1'b1;
    end else begin
      r = (mode == MODE_PRODUCT) ? mul_reduce(av, bv, mv) : pow_reduce(av, bv, mv);
      ans.result = FIELD_W'(r & OP_MASK);
      ans.error  = 1'b0;
    end
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random value exactly `bits` wide (top bit set), zero for zero bits
  function automatic bit [FIELD_W-1:0] rand_word(int unsigned bits);
    bit [63:0] v;
    if (bits == 0)
      return '0;
    v = {$urandom, $urandom};
    v = v & ((64'd1 << bits) - 64'd1);
    v[bits-1] = 1'b1;
    return FIELD_W'(v);
  endfunction

  // modulus mix: occasional zero or one, otherwise any width
  function automatic bit [FIELD_W-1:0] rand_modulus();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)
      return '0;
    if (r < 10)
      return FIELD_W'(1);
    return rand_word($urandom_range(2, FIELD_W));
  endfunction

  // called at a rising edge; leaves valid high on return so the next word can follow
  task automatic send_word(bit mode, bit [FIELD_W-1:0] a, bit [FIELD_W-1:0] b,
                           bit [FIELD_W-1:0] m);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.mode     <= mode;
    req.base     <= a;
    req.exponent <= b;
    req.modulus  <= m;
    do @(posedge clk); while (req.ready !== 1'b1);
    answer_q.push_back(predict_answer(mode, a, b, m));
  endtask

  task automatic wait_for_drain();
    req.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_special_cases();
    // zero modulus in both modes, with and without operands
    send_word(MODE_POWER,   FIELD_W'(5), FIELD_W'(3), '0);
    send_word(MODE_PRODUCT, ALL_ONES, ALL_ONES, '0);
    send_word(MODE_POWER,   '0, '0, '0);
    send_word(MODE_PRODUCT, '0, '0, '0);
    // modulus one gives zero, including zero to the zero
    send_word(MODE_POWER,   '0, '0, FIELD_W'(1));
    send_word(MODE_PRODUCT, ALL_ONES, ALL_ONES, FIELD_W'(1));
    send_word(MODE_POWER,   ALL_ONES, ALL_ONES, FIELD_W'(1));
    // zero exponent gives one, zero base too
    send_word(MODE_POWER,   '0, '0, FIELD_W'(7));
    send_word(MODE_POWER,   ALL_ONES, '0, ALL_ONES);
    send_word(MODE_POWER,   '0, ALL_ONES, FIELD_W'(13));
    // operand extremes and reduction of operands above the modulus
    send_word(MODE_POWER,   ALL_ONES, ALL_ONES, ALL_ONES);
    send_word(MODE_POWER,   ALL_ONES, ALL_ONES, ALL_ONES - 1);
    send_word(MODE_PRODUCT, ALL_ONES, ALL_ONES, ALL_ONES - 1);
    send_word(MODE_PRODUCT, ALL_ONES, ALL_ONES, ALL_ONES);
    send_word(MODE_PRODUCT, '0, ALL_ONES, FIELD_W'(97));
    send_word(MODE_PRODUCT, ALL_ONES, '0, FIELD_W'(97));
    send_word(MODE_POWER,   FIELD_W'(1000), FIELD_W'(5), FIELD_W'(7));
    send_word(MODE_POWER,   FIELD_W'(2), FIELD_W'(10), FIELD_W'(1000));
    send_word(MODE_POWER,   FIELD_W'(3), FIELD_W'(1), FIELD_W'(2));
    send_word(MODE_PRODUCT, FIELD_W'(1), FIELD_W'(1), FIELD_W'(2));
    // alternating bit patterns
    send_word(MODE_POWER,   FIELD_W'({FIELD_W/2{2'b10}}), FIELD_W'({(FIELD_W+1)/2{2'b01}}),
              ALL_ONES - 58);
    send_word(MODE_PRODUCT, FIELD_W'(123456789), FIELD_W'(987654321), ALL_ONES - 58);
  endtask

  // most exponents short so the run stays quick, a fifth of them up to full width
  task automatic test_random_power();
    int unsigned ebits;
    for (int i = 0; i < 50; i++) begin
      ebits = ($urandom_range(0, 4) == 0) ? $urandom_range(13, FIELD_W)
                                          : $urandom_range(0, 12);
      send_word(MODE_POWER, rand_word($urandom_range(0, FIELD_W)), rand_word(ebits),
                rand_modulus());
      // hold off once until every outstanding result is back
      if (i == 25)
        wait_for_drain();
    end
  endtask

  task automatic test_random_product();
    for (int i = 0; i < 35; i++)
      send_word(MODE_PRODUCT, rand_word($urandom_range(0, FIELD_W)),
                rand_word($urandom_range(0, FIELD_W)), rand_modulus());
  endtask

  // no gaps and no stalls: a new word must be taken while the last result waits
  task automatic test_back_to_back();
    bit mode;
    steady_flow = 1'b1;
    for (int i = 0; i < 15; i++) begin
      mode = 1'($urandom_range(0, 1));
      send_word(mode, rand_word($urandom_range(0, FIELD_W)),
                rand_word((mode == MODE_POWER) ? $urandom_range(0, 8)
                                               : $urandom_range(0, FIELD_W)),
                rand_modulus());
    end
    wait_for_drain();
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // response side: random backpressure and checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
      if (!steady_flow) begin
        case ($urandom_range(0, 99)) inside
          [0:2]:   stall_left = $urandom_range(8, 40);
          [3:19]:  stall_left = $urandom_range(1, 3);
          default: stall_left = 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (answer_q.size() == 0) begin
        $error("response word with no request outstanding: result %0h error %0b",
               rsp.result, rsp.error);
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        if (rsp.result !== want.result) begin
          $error("result mismatch: expected %0h, actual %0h", want.result, rsp.result);
          fail_count++;
        end
        if (rsp.error !== want.error) begin
          $error("error mismatch: expected %0b, actual %0b", want.error, rsp.error);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst          <= 1'b1;
    req.valid    <= 1'b0;
    req.mode     <= 1'b0;
    req.base     <= '0;
    req.exponent <= '0;
    req.modulus  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_special_cases();
    test_random_power();
    test_random_product();
    test_back_to_back();

    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule : modular_exponentiation_tb
